// File: hdl/owtrs_pkg.sv
// Shared types and constants for the single-wire temperature read sequencer.
`default_nettype none

package owtrs_pkg;

    // Bus commands sent during the sequence.
    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT    = 8'h44;
    localparam logic [7:0] CMD_READ_PAD   = 8'hBE;

    // Sequence step numbers.
    localparam logic [2:0] STEP_RESET_A   = 3'd0;
    localparam logic [2:0] STEP_SKIP_A    = 3'd1;
    localparam logic [2:0] STEP_CONVERT   = 3'd2;
    localparam logic [2:0] STEP_RESET_B   = 3'd3;
    localparam logic [2:0] STEP_SKIP_B    = 3'd4;
    localparam logic [2:0] STEP_READ_PAD  = 3'd5;
    localparam logic [2:0] STEP_READ_LO   = 3'd6;
    localparam logic [2:0] STEP_READ_HI   = 3'd7;

    localparam logic [2:0] BIT_LAST       = 3'd7;

    // Sequencer phase codes.
    localparam logic [3:0] PH_IDLE        = 4'd0;
    localparam logic [3:0] PH_RST_HIGH    = 4'd1;
    localparam logic [3:0] PH_RST_LOW     = 4'd2;
    localparam logic [3:0] PH_PRES_WAIT   = 4'd3;
    localparam logic [3:0] PH_RST_TAIL    = 4'd4;
    localparam logic [3:0] PH_W_LOW       = 4'd5;
    localparam logic [3:0] PH_W_HOLD      = 4'd6;
    localparam logic [3:0] PH_R_LOW       = 4'd7;
    localparam logic [3:0] PH_R_WAIT      = 4'd8;
    localparam logic [3:0] PH_R_TAIL      = 4'd9;

    // Configuration register indexes.
    localparam logic [2:0] REG_PRE_RESET_HIGH = 3'd0;
    localparam logic [2:0] REG_RESET_LOW      = 3'd1;
    localparam logic [2:0] REG_PRESENCE_WAIT  = 3'd2;
    localparam logic [2:0] REG_RESET_TAIL     = 3'd3;
    localparam logic [2:0] REG_SLOT_LOW       = 3'd4;
    localparam logic [2:0] REG_WRITE_SLOT     = 3'd5;
    localparam logic [2:0] REG_READ_SAMPLE    = 3'd6;
    localparam logic [2:0] REG_READ_SLOT      = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Timing configuration.
    typedef struct packed {
        logic [15:0] pre_reset_high_ticks;
        logic [15:0] reset_low_ticks;
        logic [15:0] presence_wait_ticks;
        logic [15:0] reset_tail_ticks;
        logic [7:0]  slot_low_ticks;
        logic [15:0] write_slot_ticks;
        logic [7:0]  read_sample_ticks;
        logic [15:0] read_slot_ticks;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        pre_reset_high_ticks: 16'd10,
        reset_low_ticks:      16'd500,
        presence_wait_ticks:  16'd154,
        reset_tail_ticks:     16'd212,
        slot_low_ticks:       8'd1,
        write_slot_ticks:     16'd66,
        read_sample_ticks:    8'd1,
        read_slot_ticks:      16'd56
    };

    // One result per tick.
    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        logic [15:0] temperature_word;
        logic        presence_seen;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/owtrs_cfg.sv
// Timing configuration registers of the sequencer.
`default_nettype none

module owtrs_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [owtrs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [owtrs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output owtrs_pkg::t_cfg                        o_cfg
);
    import owtrs_pkg::*;

    t_cfg r_cfg;

    // Register writes; eight-bit registers keep the low byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PRE_RESET_HIGH: r_cfg.pre_reset_high_ticks <= i_cfg_data;
                REG_RESET_LOW:      r_cfg.reset_low_ticks      <= i_cfg_data;
                REG_PRESENCE_WAIT:  r_cfg.presence_wait_ticks  <= i_cfg_data;
                REG_RESET_TAIL:     r_cfg.reset_tail_ticks     <= i_cfg_data;
                REG_SLOT_LOW:       r_cfg.slot_low_ticks       <= i_cfg_data[7:0];
                REG_WRITE_SLOT:     r_cfg.write_slot_ticks     <= i_cfg_data;
                REG_READ_SAMPLE:    r_cfg.read_sample_ticks    <= i_cfg_data[7:0];
                REG_READ_SLOT:      r_cfg.read_slot_ticks      <= i_cfg_data;
                default:            r_cfg                      <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: hdl/owtrs_seq.sv
// Phase sequencer: advances one tick per accepted request and forms its result.
`default_nettype none

module owtrs_seq (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic       i_start_req,
    input  wire logic       i_line_level,
    input  wire owtrs_pkg::t_cfg i_cfg,
    output owtrs_pkg::t_result o_res
);
    import owtrs_pkg::*;

    logic [3:0]  r_phase,   n_phase;
    logic [15:0] r_tick,    n_tick;
    logic [2:0]  r_step,    n_step;
    logic [2:0]  r_bit,     n_bit;
    logic [7:0]  r_shift,   n_shift;
    logic [7:0]  r_low,     n_low;
    logic [15:0] r_word,    n_word;
    logic        r_presence, n_presence;

    logic [15:0] dur;
    logic [16:0] tick_inc;
    logic        last;
    logic [15:0] tick_adv;
    logic        enter;
    logic [2:0]  enter_step;
    logic        drive;
    logic        done;

    // Length of the current phase.
    always_comb begin
        case (r_phase)
            PH_RST_HIGH:  dur = i_cfg.pre_reset_high_ticks;
            PH_RST_LOW:   dur = i_cfg.reset_low_ticks;
            PH_PRES_WAIT: dur = i_cfg.presence_wait_ticks;
            PH_RST_TAIL:  dur = i_cfg.reset_tail_ticks;
            PH_W_LOW:     dur = {8'd0, i_cfg.slot_low_ticks};
            PH_R_LOW:     dur = {8'd0, i_cfg.slot_low_ticks};
            PH_W_HOLD:    dur = i_cfg.write_slot_ticks;
            PH_R_WAIT:    dur = {8'd0, i_cfg.read_sample_ticks};
            PH_R_TAIL:    dur = i_cfg.read_slot_ticks;
            default:      dur = 16'd0;
        endcase
    end

    // The phase ends on the tick whose count plus one reaches its length.
    assign tick_inc = {1'b0, r_tick} + 17'd1;
    assign last     = (tick_inc >= {1'b0, dur});
    assign tick_adv = last ? 16'd0 : tick_inc[15:0];

    // Next state for one tick.
    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_step     = r_step;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_low      = r_low;
        n_word     = r_word;
        n_presence = r_presence;
        enter      = 1'b0;
        enter_step = r_step + 3'd1;
        drive      = 1'b0;
        done       = 1'b0;

        case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    enter      = 1'b1;
                    enter_step = STEP_RESET_A;
                end
            end
            PH_RST_HIGH: begin
                n_tick = tick_adv;
                if (last) begin
                    n_phase = PH_RST_LOW;
                end
            end
            PH_RST_LOW: begin
                drive  = 1'b1;
                n_tick = tick_adv;
                if (last) begin
                    n_phase = PH_PRES_WAIT;
                end
            end
            PH_PRES_WAIT: begin
                n_tick = tick_adv;
                if (last) begin
                    n_presence = ~i_line_level;
                    n_phase    = PH_RST_TAIL;
                end
            end
            PH_RST_TAIL: begin
                n_tick = tick_adv;
                if (last) begin
                    enter = 1'b1;
                end
            end
            PH_W_LOW: begin
                drive  = 1'b1;
                n_tick = tick_adv;
                if (last) begin
                    n_phase = PH_W_HOLD;
                end
            end
            PH_W_HOLD: begin
                drive  = ~r_shift[0];
                n_tick = tick_adv;
                if (last) begin
                    n_shift = {1'b0, r_shift[7:1]};
                    if (r_bit == BIT_LAST) begin
                        enter = 1'b1;
                    end else begin
                        n_bit   = r_bit + 3'd1;
                        n_phase = PH_W_LOW;
                    end
                end
            end
            PH_R_LOW: begin
                drive  = 1'b1;
                n_tick = tick_adv;
                if (last) begin
                    n_phase = PH_R_WAIT;
                end
            end
            PH_R_WAIT: begin
                n_tick = tick_adv;
                if (last) begin
                    n_shift = {i_line_level, r_shift[7:1]};
                    n_phase = PH_R_TAIL;
                end
            end
            PH_R_TAIL: begin
                n_tick = tick_adv;
                if (last) begin
                    if (r_bit != BIT_LAST) begin
                        n_bit   = r_bit + 3'd1;
                        n_phase = PH_R_LOW;
                    end else if (r_step == STEP_READ_LO) begin
                        n_low      = r_shift;
                        enter      = 1'b1;
                        enter_step = STEP_READ_HI;
                    end else begin
                        n_word  = {r_shift, r_low};
                        done    = 1'b1;
                        n_phase = PH_IDLE;
                        n_tick  = 16'd0;
                        n_step  = STEP_RESET_A;
                        n_bit   = 3'd0;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = 16'd0;
            end
        endcase

        // Start of a new step: reset slot, command byte or read byte.
        if (enter) begin
            n_step = enter_step;
            n_tick = 16'd0;
            n_bit  = 3'd0;
            case (enter_step)
                STEP_RESET_A, STEP_RESET_B: begin
                    n_phase = PH_RST_HIGH;
                end
                STEP_SKIP_A, STEP_SKIP_B: begin
                    n_shift = CMD_SKIP_ROM;
                    n_phase = PH_W_LOW;
                end
                STEP_CONVERT: begin
                    n_shift = CMD_CONVERT;
                    n_phase = PH_W_LOW;
                end
                STEP_READ_PAD: begin
                    n_shift = CMD_READ_PAD;
                    n_phase = PH_W_LOW;
                end
                default: begin
                    n_shift = 8'd0;
                    n_phase = PH_R_LOW;
                end
            endcase
        end
    end

    // State advances only on an accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_tick     <= 16'd0;
            r_step     <= STEP_RESET_A;
            r_bit      <= 3'd0;
            r_shift    <= 8'd0;
            r_low      <= 8'd0;
            r_word     <= 16'd0;
            r_presence <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_tick     <= n_tick;
            r_step     <= n_step;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_low      <= n_low;
            r_word     <= n_word;
            r_presence <= n_presence;
        end
    end

    // Drive and busy describe the tick as it starts; the rest follow the update.
    assign o_res.drive_low        = drive;
    assign o_res.busy_res         = (r_phase != PH_IDLE);
    assign o_res.done_res         = done;
    assign o_res.temperature_word = n_word;
    assign o_res.presence_seen    = n_presence;

endmodule

`default_nettype wire

// File: hdl/onewire_temperature_read_sequencer.sv
// Top level: configuration, tick sequencer and output skid buffer.
// A result is registered in the main output register, or in skid under output stall.
// One request per cycle unless stalled; sequencer state is a single register stage.
// A two-entry output buffer lets a request be taken while a result waits to be read;
// input stall rises only when both entries are full.
// Reset (synchronous, active low) restores the register defaults and an idle sequencer.
`default_nettype none

module onewire_temperature_read_sequencer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output      logic                              o_stall,
    input  wire logic                              i_start_req,
    input  wire logic                              i_line_level,
    output      logic                              o_valid,
    input  wire logic                              i_stall,
    output      logic                              o_drive_low,
    output      logic                              o_busy_res,
    output      logic                              o_done_res,
    output      logic [15:0]                       o_temperature_word,
    output      logic                              o_presence_seen,
    input  wire logic                              i_cfg_we,
    input  wire logic [owtrs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [owtrs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import owtrs_pkg::*;

    t_cfg    cfg;
    t_result res;
    t_result r_main;
    t_result r_skid;
    logic    r_main_valid;
    logic    r_skid_valid;
    logic    accept;
    logic    out_take;

    assign o_stall  = r_skid_valid;
    assign accept   = i_valid & ~r_skid_valid;
    assign out_take = r_main_valid & ~i_stall;

    owtrs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    owtrs_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_start_req  (i_start_req),
        .i_line_level (i_line_level),
        .i_cfg        (cfg),
        .o_res        (res)
    );

    // Output buffer: main register feeds the port, skid catches a request under stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || out_take) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload moves without reset.
    always_ff @(posedge i_clk) begin
        if (!r_main_valid || out_take) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (accept) begin
                r_main <= res;
            end
        end else if (accept) begin
            r_skid <= res;
        end
    end

    assign o_valid            = r_main_valid;
    assign o_drive_low        = r_main.drive_low;
    assign o_busy_res         = r_main.busy_res;
    assign o_done_res         = r_main.done_res;
    assign o_temperature_word = r_main.temperature_word;
    assign o_presence_seen    = r_main.presence_seen;

endmodule

`default_nettype wire

// File: hdl/owtrs_checker.sv
// Port-level checks for the sequencer, bound to the top level.
`default_nettype none

module owtrs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_drive_low,
    input wire logic        o_busy_res,
    input wire logic        o_done_res,
    input wire logic [15:0] o_temperature_word
);

    // Input stall is only raised while a result is already waiting.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result pending");

    // A finished word is reported on a tick that belongs to the sequence.
    a_done_is_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> o_busy_res)
        else $error("done reported on an idle tick");

    // The bus is never pulled low while the sequencer is idle.
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_busy_res) |-> !o_drive_low)
        else $error("bus driven while idle");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_temperature_word)))
        else $error("stalled result changed");

endmodule

bind onewire_temperature_read_sequencer owtrs_checker u_owtrs_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_drive_low        (o_drive_low),
    .o_busy_res         (o_busy_res),
    .o_done_res         (o_done_res),
    .o_temperature_word (o_temperature_word)
);

`default_nettype wire
